FILE: hw/rtl/cfifo_pkg.sv
// ----------------------------------------------------------------------------
// Circular FIFO package
// Item types, operation and status codes, and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cfifo_pkg;

    localparam logic [1:0] MODE_LIST   = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [2:0] ST_ADDED        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW     = 3'd1;
    localparam logic [2:0] ST_REMOVED      = 3'd2;
    localparam logic [2:0] ST_REMOVED_LAST = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW    = 3'd4;
    localparam logic [2:0] ST_LISTED       = 3'd5;
    localparam logic [2:0] ST_EMPTY        = 3'd6;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] data;
        logic               last;
    } t_out;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_OVERFLOW,
        OP_REMOVE,
        OP_UNDERFLOW,
        OP_LIST,
        OP_EMPTY
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic list_last;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/cfifo_ctrl.sv
// ----------------------------------------------------------------------------
// Circular FIFO controller
// Accepts one item at a time, holds its operation code and issues one
// datapath command per cycle while the output register can take a result.
// ----------------------------------------------------------------------------
module cfifo_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_mode,
    output logic              o_in_stall,
    input  cfifo_pkg::t_sts   i_sts,
    output cfifo_pkg::t_cmd   o_cmd
);
    import cfifo_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_mode, n_mode;
    logic       accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        o_cmd.load = 1'b0;
        o_cmd.op   = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_mode     = i_mode;
                    if (i_mode == MODE_LIST || i_mode == MODE_ADD || i_mode == MODE_REMOVE) begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                    unique case (r_mode)
                        MODE_ADD: begin
                            o_cmd.op = i_sts.full ? OP_OVERFLOW : OP_ADD;
                        end
                        MODE_REMOVE: begin
                            o_cmd.op = i_sts.empty ? OP_UNDERFLOW : OP_REMOVE;
                        end
                        MODE_LIST: begin
                            if (i_sts.empty) begin
                                o_cmd.op = OP_EMPTY;
                            end else begin
                                o_cmd.op = OP_LIST;
                                if (!i_sts.list_last) begin
                                    n_state = S_EXEC;
                                end
                            end
                        end
                        default: begin
                            o_cmd.op = OP_NONE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MODE_LIST;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

endmodule

FILE: hw/rtl/cfifo_dp.sv
// ----------------------------------------------------------------------------
// Circular FIFO datapath
// Slot memory with a registered read port, head, tail and fill registers,
// the listing walk pointer and the output register.
// ----------------------------------------------------------------------------
module cfifo_dp #(
    parameter int DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfifo_pkg::t_in    i_in_data,
    input  cfifo_pkg::t_cmd   i_cmd,
    output cfifo_pkg::t_sts   o_sts,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cfifo_pkg::t_out   o_out_data
);
    import cfifo_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [PW-1:0] next_idx(input logic [PW-1:0] idx);
        logic [PW-1:0] res;
        res = (idx == PW'(DEPTH - 1)) ? '0 : idx + 1'b1;
        return res;
    endfunction

    logic signed [31:0] mem [DEPTH];

    logic [PW-1:0]      r_head, r_tail, r_ptr;
    logic [CW-1:0]      r_fill, r_cnt;
    logic signed [31:0] r_value, r_rd_data;
    logic               r_out_valid;
    t_out               r_out;

    logic               list_last;
    logic               out_free;
    logic               rd_en;
    logic [PW-1:0]      rd_addr;

    assign list_last = (r_cnt == r_fill);
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_sts.empty     = (r_fill == '0);
    assign o_sts.full      = (r_fill == CW'(DEPTH));
    assign o_sts.list_last = list_last;
    assign o_sts.out_free  = out_free;

    assign rd_en   = i_cmd.load || (i_cmd.op == OP_LIST && !list_last);
    assign rd_addr = i_cmd.load ? r_head : r_ptr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ADD) begin
            mem[r_tail] <= r_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_in_data.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
            r_ptr  <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_ptr <= next_idx(r_head);
                r_cnt <= CW'(1);
            end
            case (i_cmd.op)
                OP_ADD: begin
                    r_tail <= next_idx(r_tail);
                    r_fill <= r_fill + 1'b1;
                end
                OP_REMOVE: begin
                    r_head <= next_idx(r_head);
                    r_fill <= r_fill - 1'b1;
                end
                OP_LIST: begin
                    if (!list_last) begin
                        r_ptr <= next_idx(r_ptr);
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op != OP_NONE) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ADD: begin
                r_out <= '{status: ST_ADDED, data: r_value, last: 1'b1};
            end
            OP_OVERFLOW: begin
                r_out <= '{status: ST_OVERFLOW, data: '0, last: 1'b1};
            end
            OP_REMOVE: begin
                r_out <= '{status: (r_fill == CW'(1)) ? ST_REMOVED_LAST : ST_REMOVED,
                           data: r_rd_data, last: 1'b1};
            end
            OP_UNDERFLOW: begin
                r_out <= '{status: ST_UNDERFLOW, data: '0, last: 1'b1};
            end
            OP_LIST: begin
                r_out <= '{status: ST_LISTED, data: r_rd_data, last: list_last};
            end
            OP_EMPTY: begin
                r_out <= '{status: ST_EMPTY, data: '0, last: 1'b1};
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/circular_fifo_with_listing.sv
// ----------------------------------------------------------------------------
// Circular FIFO with listing
// A queue of up to DEPTH signed 32-bit words. Each input item adds a word,
// removes the oldest word or lists every stored word from oldest to newest.
//
// Both channels use valid and stall; an item moves on an edge where valid is
// high and stall is low. Results leave through one output register.
// An add or a remove yields one result, and the next item is taken only
// after that result is registered, so the block never takes a new item
// before it is through with the last one. A listing of N entries streams
// one result per cycle while the output is not stalled and holds off the
// next item until its last entry is registered; the walk pointer and the
// slot memory with its registered read set this pace. An empty listing
// gives one result. Mode 3 is taken and dropped with no result.
// While the receiver stalls, the output register holds its result and the
// block waits with the next result. Reset empties the queue and clears the
// output valid flag; the slot memory is not cleared.
// ----------------------------------------------------------------------------
module circular_fifo_with_listing #(
    parameter int DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cfifo_pkg::t_in    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cfifo_pkg::t_out   o_out_data
);
    import cfifo_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cfifo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_data.mode),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cfifo_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: dv/circular_fifo_with_listing_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Circular FIFO with listing testbench
// Drives a table of directed items (empty and full queue, extreme words,
// wrap-round, the unused mode), then several hundred random items biased in
// turn towards filling and draining the queue. Every result is compared with
// a queue model kept alongside the block. Both sides idle at random, and the
// receiver holds off once for long enough to back the block up.
// ----------------------------------------------------------------------------
module circular_fifo_with_listing_tb;
    import cfifo_pkg::*;

    localparam int DEPTH       = 8;
    localparam int PW          = $clog2(DEPTH);
    localparam int RAND_ITEMS  = 370;
    localparam int HOLD_CYCLES = 60;
    localparam int IDLE_LIMIT  = 1000;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        t_in  itm;
        bit   typed;
        t_out res;
    } t_plan_row;

    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic in_valid   = 1'b0;
    t_in  in_data    = '0;
    logic out_stall  = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    bit   quiet       = 1'b0;
    bit   hold_req    = 1'b0;
    bit   hold_served = 1'b0;
    int   hold_cnt    = 0;
    int   mismatches  = 0;

    t_out               results_due [$];
    t_plan_row          plan [$];
    logic signed [31:0] ring [DEPTH];
    logic [PW-1:0]      ring_head = '0;
    logic [PW-1:0]      ring_tail = '0;
    int                 ring_fill = 0;

    circular_fifo_with_listing #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [PW-1:0] ring_step(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic void owe_result(input logic [2:0] status, input logic signed [31:0] data,
                                       input logic last);
        t_out r;
        r.status = status;
        r.data   = data;
        r.last   = last;
        results_due.push_back(r);
    endfunction

    function automatic void model_queue(input t_in itm);
        logic [PW-1:0] idx;
        int            n;
        idx = ring_head;
        case (itm.mode)
            MODE_LIST: begin
                if (ring_fill == 0)
                    owe_result(ST_EMPTY, '0, 1'b1);
                for (n = 0; n < ring_fill; n++) begin
                    owe_result(ST_LISTED, ring[idx], n == ring_fill - 1);
                    idx = ring_step(idx);
                end
            end
            MODE_ADD: begin
                if (ring_fill == DEPTH) begin
                    owe_result(ST_OVERFLOW, '0, 1'b1);
                end else begin
                    ring[ring_tail] = itm.value;
                    ring_tail = ring_step(ring_tail);
                    ring_fill++;
                    owe_result(ST_ADDED, itm.value, 1'b1);
                end
            end
            MODE_REMOVE: begin
                if (ring_fill == 0) begin
                    owe_result(ST_UNDERFLOW, '0, 1'b1);
                end else begin
                    ring_head = ring_step(ring_head);
                    ring_fill--;
                    owe_result((ring_fill == 0) ? ST_REMOVED_LAST : ST_REMOVED, ring[idx], 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void plan_row(input logic [1:0] mode, input logic signed [31:0] value,
                                     input bit typed, input logic [2:0] status,
                                     input logic signed [31:0] data);
        t_plan_row r;
        r.itm.mode   = mode;
        r.itm.value  = value;
        r.typed      = typed;
        r.res.status = status;
        r.res.data   = data;
        r.res.last   = 1'b1;
        plan.push_back(r);
    endfunction

    task automatic send_item(input t_in itm);
        @(negedge i_clk);
        while (!quiet && $urandom_range(99) < 28) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= itm;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic report(input string field, input longint want, input longint got);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        mismatches++;
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_served) begin
                out_stall <= 1'b1;
                hold_cnt++;
                if (hold_cnt == HOLD_CYCLES)
                    hold_served = 1'b1;
            end else begin
                out_stall <= !quiet && ($urandom_range(99) < 28);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && out_valid === 1'b1 && !out_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got status %0d data %0d last %0d",
                         $time, out_data.status, out_data.data, out_data.last);
                mismatches++;
            end else begin
                want = results_due.pop_front();
                if (out_data.status !== want.status)
                    report("status", want.status, out_data.status);
                if (out_data.data !== want.data)
                    report("data", want.data, out_data.data);
                if (out_data.last !== want.last)
                    report("last", want.last, out_data.last);
            end
        end
    end

    initial begin
        int idle_run;
        idle_run = 0;
        while (idle_run < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        t_plan_row     r;
        t_in           itm;
        int            k;
        int            pick;
        int            force_adds;
        bit            lean_add;
        force_adds = 0;
        lean_add   = 1'b1;

        plan_row(MODE_LIST,   32'sd0,        1, ST_EMPTY,        32'sd0);
        plan_row(MODE_REMOVE, 32'sd0,        1, ST_UNDERFLOW,    32'sd0);
        plan_row(MODE_UNUSED, 32'hFFFFFFFF,  0, ST_ADDED,        32'sd0);
        plan_row(MODE_ADD,    32'h7FFFFFFF,  1, ST_ADDED,        32'h7FFFFFFF);
        plan_row(MODE_LIST,   32'sd0,        0, ST_ADDED,        32'sd0);
        plan_row(MODE_REMOVE, 32'sd0,        1, ST_REMOVED_LAST, 32'h7FFFFFFF);
        plan_row(MODE_ADD,    32'h80000000,  1, ST_ADDED,        32'h80000000);
        plan_row(MODE_ADD,    32'hFFFFFFFF,  1, ST_ADDED,        32'hFFFFFFFF);
        plan_row(MODE_REMOVE, 32'sd0,        0, ST_ADDED,        32'sd0);
        plan_row(MODE_ADD,    32'sd0,        1, ST_ADDED,        32'sd0);
        plan_row(MODE_ADD,    32'h55555555,  1, ST_ADDED,        32'h55555555);
        plan_row(MODE_ADD,    32'hAAAAAAAA,  1, ST_ADDED,        32'hAAAAAAAA);
        plan_row(MODE_ADD,    32'sd1,        1, ST_ADDED,        32'sd1);
        plan_row(MODE_ADD,    32'h12345678,  1, ST_ADDED,        32'h12345678);
        plan_row(MODE_ADD,    32'hFEDCBA98,  1, ST_ADDED,        32'hFEDCBA98);
        plan_row(MODE_ADD,    32'h7FFFFFFF,  1, ST_ADDED,        32'h7FFFFFFF);
        plan_row(MODE_ADD,    32'sd2,        1, ST_OVERFLOW,     32'sd0);
        plan_row(MODE_LIST,   32'sd0,        0, ST_ADDED,        32'sd0);
        plan_row(MODE_REMOVE, 32'sd0,        0, ST_ADDED,        32'sd0);
        plan_row(MODE_REMOVE, 32'sd0,        0, ST_ADDED,        32'sd0);
        plan_row(MODE_ADD,    32'sd3,        1, ST_ADDED,        32'sd3);
        plan_row(MODE_LIST,   32'sd0,        0, ST_ADDED,        32'sd0);
        plan_row(MODE_UNUSED, 32'sd0,        0, ST_ADDED,        32'sd0);
        plan_row(MODE_REMOVE, 32'sd0,        0, ST_ADDED,        32'sd0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[j]) begin
            r = plan[j];
            send_item(r.itm);
            model_queue(r.itm);
            if (r.typed) begin
                void'(results_due.pop_back());
                results_due.push_back(r.res);
            end
        end

        // The queue is pushed towards full and then towards empty in turns, so that
        // overflow, underflow and wrap-round come up often with random words.
        for (k = 0; k < RAND_ITEMS; k++) begin
            if (k % 24 == 0)
                lean_add = !lean_add;
            quiet = (k >= 160 && k < 230);
            if (k == 120) begin
                hold_req   = 1'b1;
                force_adds = 14;
            end
            pick = $urandom_range(99);
            if (force_adds > 0) begin
                itm.mode = MODE_ADD;
                force_adds--;
            end else if (pick < 4) begin
                itm.mode = MODE_UNUSED;
            end else if (pick < 22) begin
                itm.mode = MODE_LIST;
            end else if (pick < (lean_add ? 72 : 42)) begin
                itm.mode = MODE_ADD;
            end else begin
                itm.mode = MODE_REMOVE;
            end
            case ($urandom_range(9))
                0: itm.value = 32'h7FFFFFFF;
                1: itm.value = 32'h80000000;
                2: itm.value = $urandom_range(1) ? 32'hFFFFFFFF : 32'sd0;
                default: itm.value = $urandom;
            endcase
            send_item(itm);
            model_queue(itm);
        end

        @(negedge i_clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (2 * DEPTH + 8) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: circular_fifo_with_listing.f
hw/rtl/cfifo_pkg.sv
hw/rtl/cfifo_ctrl.sv
hw/rtl/cfifo_dp.sv
hw/rtl/circular_fifo_with_listing.sv
dv/circular_fifo_with_listing_tb.sv
